// ===== sv/rbsi_pkg.sv =====
// rbsi_pkg: shared constants for the ray versus box slab test
// field counts, field widths and field positions on the stream ports
// no dependencies
package rbsi_pkg;

  localparam int FIELD_W     = 32;
  localparam int N_AXES      = 3;
  localparam int IN_FIELDS   = 12;
  localparam int OUT_FIELDS  = 8;
  localparam int IN_TDATA_W  = FIELD_W * IN_FIELDS;
  localparam int OUT_TDATA_W = FIELD_W * OUT_FIELDS;

  // input field groups, each followed by x, y, z
  localparam int F_BOX_LOW  = 0;
  localparam int F_BOX_HIGH = 3;
  localparam int F_ORIGIN   = 6;
  localparam int F_DIR      = 9;

  // output field positions in out_tdata
  localparam int O_NEAR_PARAM = 0;
  localparam int O_FAR_PARAM  = 1;
  localparam int O_NEAR_POS   = 2;
  localparam int O_FAR_POS    = 5;

endpackage

// ===== sv/rbsi_delay.sv =====
// rbsi_delay: enabled register chain that carries valid bits and side data
// along with the long arithmetic paths; no package dependency
module rbsi_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] stage_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r[0] <= '0;
    end else if (en) begin
      stage_r[0] <= d;
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[i] <= '0;
      end else if (en) begin
        stage_r[i] <= stage_r[i-1];
      end
    end
  end

  assign q = stage_r[DEPTH-1];

endmodule

// ===== sv/rbsi_slab_div.sv =====
// rbsi_slab_div: pipelined restoring divider, one quotient bit per stage
// computes (num << F) / den toward zero with saturation to the word range
module rbsi_slab_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [W:0]          num_mag,
  input  logic [W-1:0]        den_mag,
  input  logic                neg,
  output logic signed [W-1:0] t
);

  localparam int NB = W + 1 + F;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]  rem_r [NB+1];
  logic [NB-1:0] dq_r  [NB+1];
  logic [W-1:0]  den_r [NB+1];
  logic          neg_r [NB+1];
  logic [W-1:0]  t_r;
  logic [NB-1:0] q;
  logic          big;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dq_r[0]  <= {num_mag, {F{1'b0}}};
      den_r[0] <= den_mag;
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_bit
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    assign trial = {rem_r[i], dq_r[i][NB-1]};
    assign diff  = trial - {1'b0, den_r[i]};
    assign ge    = trial >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? diff[W-1:0] : trial[W-1:0];
        dq_r[i+1]  <= {dq_r[i][NB-2:0], ge};
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // saturate the magnitude, then apply the sign
  assign q   = dq_r[NB];
  assign big = |q[NB-1:W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[NB]) begin
        t_r <= big ? WMIN : (~q[W-1:0] + 1'b1);
      end else begin
        t_r <= big ? WMAX : q[W-1:0];
      end
    end
  end

  assign t = t_r;

endmodule

// ===== sv/rbsi_ray_point.sv =====
// rbsi_ray_point: origin + floor(dir * t / 2^F), saturated, two stages
// stage one multiplies, stage two shifts, adds and clamps
module rbsi_ray_point #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] org,
  input  logic signed [W-1:0] dir,
  input  logic signed [W-1:0] t,
  output logic signed [W-1:0] pos
);

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [2*W-1:0] prod_r;
  logic signed [W-1:0]   org_r;
  logic signed [2*W-1:0] sh;
  logic [2*W:0]          sum;
  logic [W+1:0]          top;
  logic [W-1:0]          pos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= dir * t;
      org_r  <= org;
    end
  end

  assign sh  = prod_r >>> F;
  assign sum = {sh[2*W-1], sh} + {{(W+1){org_r[W-1]}}, org_r};
  assign top = sum[2*W:W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if ((top == '0) || (&top)) begin
        pos_r <= sum[W-1:0];
      end else begin
        pos_r <= sum[2*W] ? WMIN : WMAX;
      end
    end
  end

  assign pos = pos_r;

endmodule

// ===== sv/ray_box_slab_intersect.sv =====
// ray_box_slab_intersect: ray versus axis-aligned box, slab method, fixed point
// uses rbsi_pkg, rbsi_delay, rbsi_slab_div and rbsi_ray_point
//
//   port group   dir   tdata                                   tuser
//   in_*         in    12 x 32: box low, box high, origin, dir  -
//   out_*        out   8 x 32: params, near and far points      hit
//
// one transfer per cycle on each side while the skid register is empty; pipeline
// depth is set by the bit-per-stage dividers (Q16.16 with the default widths)
// rst_n clears the valid bits and the delay chains; the pipeline then runs empty
// a stall on out_tready first fills a one-entry skid register, then holds
// the whole pipeline through in_tready
module ray_box_slab_intersect #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // box_low_x/y/z, box_high_x/y/z, origin_x/y/z, dir_x/y/z, 32 bits each
  input  logic [rbsi_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // near_param, far_param, near_pos_x/y/z, far_pos_x/y/z, 32 bits each
  output logic [rbsi_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // hit
  output logic [0:0]                         out_tuser
);

  import rbsi_pkg::*;

  localparam int W       = WORD_BITS;
  localparam int F       = FRAC_BITS;
  localparam int NB      = W + 1 + F;
  localparam int DIV_LAT = NB + 2;
  localparam int SIDE_W  = 2 + N_AXES + 2 * N_AXES * W;
  localparam int PT_W    = 2 + 2 * W;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // stage a: input capture
  logic                  a_v_r;
  logic [IN_TDATA_W-1:0] a_data_r;
  logic signed [W-1:0]   a_word [IN_FIELDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_data_r <= in_tdata;
    end
  end

  for (genvar i = 0; i < IN_FIELDS; i++) begin : g_in_word
    if (W <= FIELD_W) begin : g_narrow
      assign a_word[i] = a_data_r[i*FIELD_W +: W];
    end else begin : g_wide
      assign a_word[i] = {{(W-FIELD_W){a_data_r[i*FIELD_W+FIELD_W-1]}},
                          a_data_r[i*FIELD_W +: FIELD_W]};
    end
  end

  // stage b: slab differences, magnitudes and zero-direction checks
  logic                  b_v_r;
  logic                  b_miss_r;
  logic [N_AXES-1:0]     b_zero_r;
  logic [N_AXES*W-1:0]   b_org_r;
  logic [N_AXES*W-1:0]   b_dir_r;
  logic [W:0]            b_nlo_r  [N_AXES];
  logic [W:0]            b_nhi_r  [N_AXES];
  logic [W-1:0]          b_den_r  [N_AXES];
  logic                  b_neglo_r[N_AXES];
  logic                  b_neghi_r[N_AXES];
  logic [N_AXES-1:0]     a_out_slab;
  logic [N_AXES-1:0]     a_zero;

  for (genvar a = 0; a < N_AXES; a++) begin : g_prep
    logic signed [W-1:0] lo, hi, org, dir, smin, smax;
    logic signed [W:0]   dlo, dhi;
    assign lo   = a_word[F_BOX_LOW + a];
    assign hi   = a_word[F_BOX_HIGH + a];
    assign org  = a_word[F_ORIGIN + a];
    assign dir  = a_word[F_DIR + a];
    assign dlo  = {lo[W-1], lo} - {org[W-1], org};
    assign dhi  = {hi[W-1], hi} - {org[W-1], org};
    assign smin = (lo < hi) ? lo : hi;
    assign smax = (lo < hi) ? hi : lo;
    assign a_zero[a]     = (dir == '0);
    assign a_out_slab[a] = a_zero[a] && ((org < smin) || (org > smax));

    always_ff @(posedge clk) begin
      if (en) begin
        b_nlo_r[a]   <= dlo[W] ? (~dlo + 1'b1) : dlo;
        b_nhi_r[a]   <= dhi[W] ? (~dhi + 1'b1) : dhi;
        b_den_r[a]   <= dir[W-1] ? (~dir + 1'b1) : dir;
        b_neglo_r[a] <= dlo[W] ^ dir[W-1];
        b_neghi_r[a] <= dhi[W] ^ dir[W-1];
        b_org_r[a*W +: W] <= org;
        b_dir_r[a*W +: W] <= dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_miss_r <= |a_out_slab;
      b_zero_r <= a_zero;
    end
  end

  // slab dividers
  logic signed [W-1:0] t_lo [N_AXES];
  logic signed [W-1:0] t_hi [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_div
    rbsi_slab_div #(.W(W), .F(F)) u_div_lo (
      .clk     (clk),
      .en      (en),
      .num_mag (b_nlo_r[a]),
      .den_mag (b_den_r[a]),
      .neg     (b_neglo_r[a]),
      .t       (t_lo[a])
    );
    rbsi_slab_div #(.W(W), .F(F)) u_div_hi (
      .clk     (clk),
      .en      (en),
      .num_mag (b_nhi_r[a]),
      .den_mag (b_den_r[a]),
      .neg     (b_neghi_r[a]),
      .t       (t_hi[a])
    );
  end

  logic [SIDE_W-1:0]   side_d;
  logic                d_v;
  logic                d_miss;
  logic [N_AXES-1:0]   d_zero;
  logic [N_AXES*W-1:0] d_org;
  logic [N_AXES*W-1:0] d_dir;

  rbsi_delay #(.WIDTH(SIDE_W), .DEPTH(DIV_LAT)) u_side_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     ({b_v_r, b_miss_r, b_zero_r, b_org_r, b_dir_r}),
    .q     (side_d)
  );

  assign {d_v, d_miss, d_zero, d_org, d_dir} = side_d;

  // r1: order each pair; an axis with zero direction takes the full range
  logic                r1_v_r, r1_miss_r;
  logic [N_AXES*W-1:0] r1_org_r, r1_dir_r;
  logic signed [W-1:0] r1_e_r [N_AXES];
  logic signed [W-1:0] r1_x_r [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_order
    always_ff @(posedge clk) begin
      if (en) begin
        if (d_zero[a]) begin
          r1_e_r[a] <= WMIN;
          r1_x_r[a] <= WMAX;
        end else if (t_lo[a] < t_hi[a]) begin
          r1_e_r[a] <= t_lo[a];
          r1_x_r[a] <= t_hi[a];
        end else begin
          r1_e_r[a] <= t_hi[a];
          r1_x_r[a] <= t_lo[a];
        end
      end
    end
  end

  // r2: largest entry, smallest exit
  logic                r2_v_r, r2_miss_r;
  logic [N_AXES*W-1:0] r2_org_r, r2_dir_r;
  logic signed [W-1:0] r2_tn_r, r2_tf_r;
  logic signed [W-1:0] tn01, tf01;

  assign tn01 = (r1_e_r[0] > r1_e_r[1]) ? r1_e_r[0] : r1_e_r[1];
  assign tf01 = (r1_x_r[0] < r1_x_r[1]) ? r1_x_r[0] : r1_x_r[1];

  // r3: final miss decision
  logic                r3_v_r, r3_miss_r;
  logic [N_AXES*W-1:0] r3_org_r, r3_dir_r;
  logic signed [W-1:0] r3_tn_r, r3_tf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
    end else if (en) begin
      r1_v_r <= d_v;
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_miss_r <= d_miss;
      r1_org_r  <= d_org;
      r1_dir_r  <= d_dir;
      r2_miss_r <= r1_miss_r;
      r2_org_r  <= r1_org_r;
      r2_dir_r  <= r1_dir_r;
      r2_tn_r   <= (tn01 > r1_e_r[2]) ? tn01 : r1_e_r[2];
      r2_tf_r   <= (tf01 < r1_x_r[2]) ? tf01 : r1_x_r[2];
      r3_miss_r <= r2_miss_r || (r2_tn_r > r2_tf_r) || r2_tf_r[W-1];
      r3_org_r  <= r2_org_r;
      r3_dir_r  <= r2_dir_r;
      r3_tn_r   <= r2_tn_r;
      r3_tf_r   <= r2_tf_r;
    end
  end

  // hit points
  logic signed [W-1:0] near_pos [N_AXES];
  logic signed [W-1:0] far_pos  [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_point
    rbsi_ray_point #(.W(W), .F(F)) u_near (
      .clk (clk),
      .en  (en),
      .org (r3_org_r[a*W +: W]),
      .dir (r3_dir_r[a*W +: W]),
      .t   (r3_tn_r),
      .pos (near_pos[a])
    );
    rbsi_ray_point #(.W(W), .F(F)) u_far (
      .clk (clk),
      .en  (en),
      .org (r3_org_r[a*W +: W]),
      .dir (r3_dir_r[a*W +: W]),
      .t   (r3_tf_r),
      .pos (far_pos[a])
    );
  end

  logic [PT_W-1:0]     pt_d;
  logic                p_v, p_miss;
  logic signed [W-1:0] p_tn, p_tf;

  rbsi_delay #(.WIDTH(PT_W), .DEPTH(2)) u_pt_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     ({r3_v_r, r3_miss_r, r3_tn_r, r3_tf_r}),
    .q     (pt_d)
  );

  assign {p_v, p_miss, p_tn, p_tf} = pt_d;

  // result assembly; a miss clears every field
  logic signed [W-1:0]    res_word [OUT_FIELDS];
  logic [OUT_TDATA_W-1:0] res_pack;
  logic                   res_v_r, res_hit_r;
  logic [OUT_TDATA_W-1:0] res_data_r;

  assign res_word[O_NEAR_PARAM] = p_tn;
  assign res_word[O_FAR_PARAM]  = p_tf;

  for (genvar a = 0; a < N_AXES; a++) begin : g_res_pos
    assign res_word[O_NEAR_POS + a] = near_pos[a];
    assign res_word[O_FAR_POS + a]  = far_pos[a];
  end

  for (genvar i = 0; i < OUT_FIELDS; i++) begin : g_out_word
    if (W == FIELD_W) begin : g_same
      assign res_pack[i*FIELD_W +: FIELD_W] = res_word[i];
    end else if (W < FIELD_W) begin : g_narrow
      assign res_pack[i*FIELD_W +: FIELD_W] = {{(FIELD_W-W){res_word[i][W-1]}}, res_word[i]};
    end else begin : g_wide
      assign res_pack[i*FIELD_W +: FIELD_W] = res_word[i][FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (en) begin
      res_v_r <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_hit_r  <= !p_miss;
      res_data_r <= p_miss ? '0 : res_pack;
    end
  end

  // output register plus skid entry
  logic                   out_v_r, out_hit_r, skid_hit_r;
  logic [OUT_TDATA_W-1:0] out_data_r, skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (!out_v_r || out_tready) begin
        out_v_r <= res_v_r;
      end else if (res_v_r) begin
        skid_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!out_v_r || out_tready) begin
        out_hit_r  <= res_hit_r;
        out_data_r <= res_data_r;
      end else begin
        skid_hit_r  <= res_hit_r;
        skid_data_r <= res_data_r;
      end
    end else if (out_tready) begin
      out_hit_r  <= skid_hit_r;
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_hit_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_skid_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_tready)
    else $error("input taken while skid entry full");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_hit_r) |-> (out_data_r == '0))
    else $error("miss result carries nonzero fields");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> !skid_v_r && out_v_r)
    else $error("skid entry not moved to output on transfer");
`endif

endmodule

// ===== test/ray_box_slab_intersect_test.sv =====
// ray_box_slab_intersect_test: self-checking bench for the ray versus box slab test
// drives rays and boxes on in_*, checks hit, params and points on out_* against fixed results or a predictor
// depends on rbsi_pkg and ray_box_slab_intersect
`timescale 1ns / 100ps

module ray_box_slab_intersect_test;
  import rbsi_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int N_RANDOM = 1450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LATENCY = WB + FB + 12;

  typedef struct packed {
    logic                        hit;
    logic [OUT_TDATA_W-1:0]      data;
  } hit_result_t;

  typedef struct {
    logic [FIELD_W-1:0] f [IN_FIELDS];
    logic               has_fixed;
    hit_result_t        fixed_res;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  hit_result_t expected_hits[$];
  ray_row_t rays[$];
  int n_errors = 0;
  int idle_cycles = 0;
  int sink_wait = 0;
  bit stim_done = 1'b0;

  always #5 clk = ~clk;

  ray_box_slab_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  function automatic longint clamp_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  // (num << FB) / den toward zero, saturated
  function automatic longint slab_quotient(longint num, longint den);
    logic [63:0] mn, md, q;
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn << FB) / md;
    if ((num < 0) != (den < 0)) begin
      if (q > 64'd2147483648) return WMIN;
      return -longint'(q);
    end
    if (q > 64'd2147483647) return WMAX;
    return longint'(q);
  endfunction

  function automatic longint point_on_ray(longint org, longint dir, longint t);
    logic [63:0] p;
    longint s;
    p = (dir < 0 ? -dir : dir) * (t < 0 ? -t : t);
    if ((dir < 0) != (t < 0)) s = -longint'((p + 64'hffff) >> FB);
    else s = longint'(p >> FB);
    return clamp_word(org + s);
  endfunction

  function automatic hit_result_t predict_hit(logic [FIELD_W-1:0] f [IN_FIELDS]);
    longint lo, hi, org, dir, e, x, tn, tf, tmp;
    longint o[N_AXES], d[N_AXES];
    bit miss;
    hit_result_t r;
    tn = WMIN;
    tf = WMAX;
    miss = 1'b0;
    r = '0;
    for (int a = 0; a < N_AXES; a++) begin
      lo = longint'($signed(f[F_BOX_LOW + a]));
      hi = longint'($signed(f[F_BOX_HIGH + a]));
      org = longint'($signed(f[F_ORIGIN + a]));
      dir = longint'($signed(f[F_DIR + a]));
      o[a] = org;
      d[a] = dir;
      if (dir == 0) begin
        if (org < (lo < hi ? lo : hi) || org > (lo < hi ? hi : lo)) miss = 1'b1;
      end else begin
        e = slab_quotient(lo - org, dir);
        x = slab_quotient(hi - org, dir);
        if (e > x) begin
          tmp = e; e = x; x = tmp;
        end
        if (e > tn) tn = e;
        if (x < tf) tf = x;
      end
    end
    if (tn > tf || tf < 0) miss = 1'b1;
    if (miss) return r;
    r.hit = 1'b1;
    r.data[O_NEAR_PARAM*FIELD_W +: FIELD_W] = tn[31:0];
    r.data[O_FAR_PARAM*FIELD_W +: FIELD_W] = tf[31:0];
    for (int a = 0; a < N_AXES; a++) begin
      r.data[(O_NEAR_POS+a)*FIELD_W +: FIELD_W] = 32'(point_on_ray(o[a], d[a], tn));
      r.data[(O_FAR_POS+a)*FIELD_W +: FIELD_W] = 32'(point_on_ray(o[a], d[a], tf));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom();
      2: return 32'($signed($urandom_range(0, 32)) - 32'sd16);
      default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  task automatic add_row(input logic [31:0] v [IN_FIELDS], input bit fixed,
                         input hit_result_t res);
    ray_row_t row;
    row.f = v;
    row.has_fixed = fixed;
    row.fixed_res = res;
    rays.push_back(row);
  endtask

  task automatic build_directed();
    logic [31:0] v [IN_FIELDS];
    hit_result_t res;
    // unit box, ray along +x from the left: hit at t=1..2
    v = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000,
          32'hffff0000, 32'h8000, 32'h8000, 32'h10000, 32'h0, 32'h0};
    res = '0;
    res.hit = 1'b1;
    res.data[O_NEAR_PARAM*FIELD_W +: 32] = 32'h10000;
    res.data[O_FAR_PARAM*FIELD_W +: 32] = 32'h20000;
    res.data[(O_NEAR_POS)*FIELD_W +: 32] = 32'h0;
    res.data[(O_NEAR_POS+1)*FIELD_W +: 32] = 32'h8000;
    res.data[(O_NEAR_POS+2)*FIELD_W +: 32] = 32'h8000;
    res.data[(O_FAR_POS)*FIELD_W +: 32] = 32'h10000;
    res.data[(O_FAR_POS+1)*FIELD_W +: 32] = 32'h8000;
    res.data[(O_FAR_POS+2)*FIELD_W +: 32] = 32'h8000;
    add_row(v, 1'b1, res);
    // pointing away: exit below zero, miss
    v[F_DIR] = 32'hffff0000;
    add_row(v, 1'b1, '0);
    // all directions zero, origin inside
    v = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000,
          32'h8000, 32'h8000, 32'h8000, 32'h0, 32'h0, 32'h0};
    res = '0;
    res.hit = 1'b1;
    res.data[O_NEAR_PARAM*FIELD_W +: 32] = 32'h8000_0000;
    res.data[O_FAR_PARAM*FIELD_W +: 32] = 32'h7fff_ffff;
    for (int a = 0; a < N_AXES; a++) begin
      res.data[(O_NEAR_POS+a)*FIELD_W +: 32] = 32'h8000;
      res.data[(O_FAR_POS+a)*FIELD_W +: 32] = 32'h8000;
    end
    add_row(v, 1'b1, res);
    // zero direction, origin outside slab
    v[F_ORIGIN+1] = 32'h20000;
    add_row(v, 1'b1, '0);
    // inverted box, predictor
    v = '{32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0,
          32'hffff0000, 32'h8000, 32'h8000, 32'h10000, 32'h0, 32'h0};
    add_row(v, 1'b0, '0);
    // extremes: saturating quotients and points
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1};
    add_row(v, 1'b0, '0);
    v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h7fff_ffff, 32'h8000_0000, 32'h0,
          32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    add_row(v, 1'b0, '0);
    v = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    add_row(v, 1'b0, '0);
    v = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    add_row(v, 1'b0, '0);
    v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    add_row(v, 1'b0, '0);
    // diagonal rays touching edges and corners
    v = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000,
          32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h10000, 32'h10000, 32'h10000};
    add_row(v, 1'b0, '0);
    v = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000,
          32'h20000, 32'hffff8000, 32'h8000, 32'hffff0000, 32'h8000, 32'h3};
    add_row(v, 1'b0, '0);
  endtask

  task automatic build_random();
    logic [31:0] v [IN_FIELDS];
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 0; k < IN_FIELDS; k++) v[k] = $urandom();
      end else begin
        for (int a = 0; a < N_AXES; a++) begin
          v[F_BOX_LOW + a] = rand_coord();
          v[F_BOX_HIGH + a] = $urandom_range(0, 5) == 0 ? rand_coord()
                              : v[F_BOX_LOW + a] + $urandom_range(0, 32'h0004_0000);
          v[F_ORIGIN + a] = $urandom_range(0, 2) == 0 ? rand_coord()
                            : v[F_BOX_LOW + a] + $urandom_range(0, 32'h0002_0000)
                              - 32'h0001_0000;
          v[F_DIR + a] = rand_dir();
        end
      end
      add_row(v, 1'b0, '0);
    end
  endtask

  // source side
  initial begin
    ray_row_t row;
    int gap;
    logic [IN_TDATA_W-1:0] word_row;
    build_directed();
    build_random();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (rays.size() > 0) begin
      row = rays.pop_front();
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      for (int k = 0; k < IN_FIELDS; k++) word_row[k*FIELD_W +: FIELD_W] = row.f[k];
      in_tdata <= word_row;
      in_tvalid <= 1'b1;
      expected_hits.push_back(row.has_fixed ? row.fixed_res : predict_hit(row.f));
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // sink side
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait <= $urandom_range(0, 10);
    end else if (out_tvalid && out_tready) begin
      w = $urandom_range(0, 10);
      if (w > 0) begin
        out_tready <= 1'b0;
        sink_wait <= w - 1;
      end
    end else if (!out_tready) begin
      if (sink_wait == 0) out_tready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end
  end

  always @(posedge clk) begin
    hit_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[31:0], '0);
      end else begin
        want = expected_hits.pop_front();
        if (out_tuser[0] !== want.hit)
          report_mismatch("hit", 32'(out_tuser), 32'(want.hit));
        for (int k = 0; k < OUT_FIELDS; k++)
          if (out_tdata[k*FIELD_W +: FIELD_W] !== want.data[k*FIELD_W +: FIELD_W])
            report_mismatch($sformatf("field %0d", k), out_tdata[k*FIELD_W +: FIELD_W],
                            want.data[k*FIELD_W +: FIELD_W]);
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (expected_hits.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
